/* rtl/core/btu_pkg.sv */
// ============================================================================
// btu_pkg
// Shared types and constants of the x86 branch target unfilter.
// ============================================================================
`default_nettype none

package btu_pkg;

    localparam int EXC_DEPTH = 256;
    localparam int EXC_AW    = (EXC_DEPTH > 1) ? $clog2(EXC_DEPTH) : 1;
    localparam int EXC_CW    = $clog2(EXC_DEPTH + 1);

    typedef logic [EXC_CW-1:0] exc_cnt_t;

    localparam exc_cnt_t EXC_CNT_MAX = EXC_CW'(EXC_DEPTH);

    localparam int WIN_LEN = 5;

    typedef logic [WIN_LEN-1:0][7:0] win_t;
    typedef logic [2:0]              wcnt_t;

    localparam wcnt_t       FILL_FULL = wcnt_t'(WIN_LEN - 1);
    localparam wcnt_t       SKIP_OPND = 3'd4;
    localparam logic [31:0] END_INIT  = 32'(WIN_LEN);

    localparam logic [7:0] OP_CALL   = 8'hE8;
    localparam logic [7:0] OP_JMP    = 8'hE9;
    localparam logic [7:0] OP_ESC    = 8'h0F;
    localparam logic [7:0] JCC_LO    = 8'h80;
    localparam logic [7:0] JCC_HI    = 8'h8F;
    localparam logic [7:0] OPND_MARK = 8'h0D;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       error;
    } res_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic advance;
    } exc_ctl_t;

    typedef struct packed {
        logic        valid;
        logic        overflow;
        logic [31:0] offset;
    } exc_look_t;

endpackage

`default_nettype wire

/* rtl/core/btu_ram.sv */
// ============================================================================
// btu_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
`default_nettype none

module btu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                         aclk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/btu_exc_list.sv */
// ============================================================================
// btu_exc_list
// Exception offset list: table RAM, fill count, read pointer and head lookup.
// ============================================================================
`default_nettype none

module btu_exc_list (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire btu_pkg::exc_ctl_t ctl,
    input  wire logic [31:0]       load_offset,
    output btu_pkg::exc_look_t     look
);

    import btu_pkg::*;

    exc_cnt_t    count_reg, count_next;
    exc_cnt_t    next_reg, next_next;
    logic        byp_reg, byp_next;
    logic [31:0] byp_data_reg;
    logic [31:0] rd_data;
    logic        full;
    logic        wr_en;

    assign full  = (count_reg == EXC_CNT_MAX);
    assign wr_en = ctl.load && !full;

    always_comb begin
        priority if (ctl.clear) begin
            next_next = '0;
        end else if (ctl.advance) begin
            next_next = exc_cnt_t'(next_reg + 1'b1);
        end else begin
            next_next = next_reg;
        end

        priority if (ctl.clear) begin
            count_next = '0;
        end else if (wr_en) begin
            count_next = exc_cnt_t'(count_reg + 1'b1);
        end else begin
            count_next = count_reg;
        end

        // The RAM reads old data on a same-address write, so forward it.
        byp_next = wr_en && (next_next == count_reg);
    end

    btu_ram #(
        .WIDTH (32),
        .DEPTH (EXC_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[EXC_AW-1:0]),
        .wr_data (load_offset),
        .rd_addr (next_next[EXC_AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            next_reg  <= '0;
            byp_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            next_reg  <= next_next;
            byp_reg   <= byp_next;
        end
        byp_data_reg <= load_offset;
    end

    assign look = '{valid:    (next_reg < count_reg),
                    overflow: (ctl.load && full),
                    offset:   (byp_reg ? byp_data_reg : rd_data)};

endmodule

`default_nettype wire

/* rtl/core/btu_scan.sv */
// ============================================================================
// btu_scan
// Five-byte window with branch detection, operand conversion and end drain.
// ============================================================================
`default_nettype none

module btu_scan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               data_acc,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last,
    input  wire btu_pkg::exc_look_t exc,
    input  wire logic               room,
    output logic                    advance,
    output logic                    push,
    output btu_pkg::res_t           res,
    output logic                    flushing
);

    import btu_pkg::*;

    win_t        win_reg, win_next;
    wcnt_t       fill_reg, fill_next;
    logic [31:0] end_reg, end_next;
    wcnt_t       skip_reg, skip_next;
    logic        pend_reg, pend_next;
    logic        err_reg, err_next;
    logic        flush_reg, flush_next;
    wcnt_t       fcnt_reg, fcnt_next;

    win_t        w;
    logic        full;
    logic        is_call;
    logic        is_jcc;
    logic        scan_free;
    logic        do_branch;
    logic        hit;
    logic        conv;
    logic [31:0] v;

    always_comb begin
        w           = win_reg;
        w[fill_reg] = data_byte;
        full        = (fill_reg == FILL_FULL);
        is_call     = (w[0] == OP_CALL) || (w[0] == OP_JMP);
        is_jcc      = (w[0] == OP_ESC) && (w[1] >= JCC_LO) && (w[1] <= JCC_HI);
        scan_free   = !pend_reg && (skip_reg == '0);
        do_branch   = pend_reg || (scan_free && is_call);
        hit         = exc.valid && (exc.offset == end_reg);
        conv        = do_branch && !hit && (w[1] == OPND_MARK);
        v           = {8'h00, w[2], w[3], w[4]} - end_reg;

        win_next   = win_reg;
        fill_next  = fill_reg;
        end_next   = end_reg;
        skip_next  = skip_reg;
        pend_next  = pend_reg;
        err_next   = err_reg | exc.overflow;
        flush_next = flush_reg;
        fcnt_next  = fcnt_reg;
        advance    = 1'b0;
        push       = 1'b0;
        res        = '{data: win_reg[0], last: (fcnt_reg == 3'd1), error: err_reg};

        if (flush_reg) begin
            if (room) begin
                push = 1'b1;
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    win_next[i] = win_reg[i + 1];
                end
                fcnt_next = wcnt_t'(fcnt_reg - 1'b1);
                if (fcnt_reg == 3'd1) begin
                    flush_next = 1'b0;
                end
            end
        end else if (data_acc) begin
            if (full) begin
                advance = do_branch && hit;
                if (conv) begin
                    w[1]      = v[7:0];
                    w[2]      = v[15:8];
                    w[3]      = v[23:16];
                    w[4]      = v[31:24];
                    skip_next = SKIP_OPND;
                end else if (!pend_reg && (skip_reg != '0)) begin
                    skip_next = wcnt_t'(skip_reg - 1'b1);
                end
                pend_next = scan_free && !is_call && is_jcc && !last;
                if (scan_free && !is_call && is_jcc && last) begin
                    err_next = 1'b1;
                end
                push = 1'b1;
                res  = '{data: w[0], last: 1'b0, error: err_next};
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    win_next[i] = w[i + 1];
                end
                win_next[WIN_LEN-1] = w[WIN_LEN-1];
                end_next = end_reg + 32'd1;
            end else begin
                win_next  = w;
                fill_next = wcnt_t'(fill_reg + 1'b1);
            end
            if (last) begin
                flush_next = 1'b1;
                fcnt_next  = full ? FILL_FULL : wcnt_t'(fill_reg + 1'b1);
                fill_next  = '0;
                end_next   = END_INIT;
                skip_next  = '0;
                pend_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            end_reg   <= END_INIT;
            skip_reg  <= '0;
            pend_reg  <= 1'b0;
            err_reg   <= 1'b0;
            flush_reg <= 1'b0;
            fcnt_reg  <= '0;
        end else begin
            fill_reg  <= fill_next;
            end_reg   <= end_next;
            skip_reg  <= skip_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
            flush_reg <= flush_next;
            fcnt_reg  <= fcnt_next;
        end
        win_reg <= win_next;
    end

    assign flushing = flush_reg;

endmodule

`default_nettype wire

/* rtl/core/btu_skid.sv */
// ============================================================================
// btu_skid
// Two-entry result buffer that decouples the output handshake from the input.
// ============================================================================
`default_nettype none

module btu_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire btu_pkg::res_t push_res,
    output logic               room,
    output logic               m_valid,
    output btu_pkg::res_t      m_res,
    input  wire logic          m_ready
);

    import btu_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    res_t       ent0_reg, ent0_next;
    res_t       ent1_reg, ent1_next;
    logic       pop;

    assign pop = (cnt_reg != 2'd0) && m_ready;

    always_comb begin
        cnt_next  = cnt_reg;
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        priority if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                ent0_next = push_res;
            end else begin
                ent0_next = ent1_reg;
                ent1_next = push_res;
            end
        end else if (push) begin
            cnt_next = 2'(cnt_reg + 1'b1);
            if (cnt_reg == 2'd0) begin
                ent0_next = push_res;
            end else begin
                ent1_next = push_res;
            end
        end else if (pop) begin
            cnt_next  = 2'(cnt_reg - 1'b1);
            ent0_next = ent1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign room    = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_res   = ent0_reg;

endmodule

`default_nettype wire

/* rtl/core/x86_branch_target_unfilter_top.sv */
// ============================================================================
// x86_branch_target_unfilter_top
// Streaming reverse branch filter for decompressed x86 code.
// ============================================================================
// The block takes one transfer per clock while s_tready is high, both
// exception offset loads and section bytes, and each data byte that fills
// the five-byte window puts one filtered byte out through a two-entry output
// buffer, so a steady stream with m_tready high runs at one byte per cycle.
// A data byte with tlast drains the window afterwards: s_tready stays low
// while the remaining bytes, up to four, leave one per cycle as the buffer
// has room. Exception offsets sit in a 256-entry RAM with one read port whose
// head entry is prefetched; it needs no clearing pass after reset.
`default_nettype none

module x86_branch_target_unfilter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // exc_end_offset[31:0], data_byte[39:32]
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tlast,
    output logic             m_tuser    // error
);

    import btu_pkg::*;

    logic      s_acc;
    logic      data_acc;
    logic      room;
    logic      flushing;
    logic      push;
    logic      exc_advance;
    res_t      push_res;
    res_t      m_res;
    exc_ctl_t  exc_ctl;
    exc_look_t exc_look;

    assign s_tready = !flushing && room;
    assign s_acc    = s_tvalid && s_tready;
    assign data_acc = s_acc && s_tuser;

    assign exc_ctl = '{load:    (s_acc && !s_tuser),
                       clear:   (data_acc && s_tlast),
                       advance: exc_advance};

    btu_exc_list u_exc_list (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (exc_ctl),
        .load_offset (s_tdata[31:0]),
        .look        (exc_look)
    );

    btu_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_acc  (data_acc),
        .data_byte (s_tdata[39:32]),
        .last      (s_tlast),
        .exc       (exc_look),
        .room      (room),
        .advance   (exc_advance),
        .push      (push),
        .res       (push_res),
        .flushing  (flushing)
    );

    btu_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .room     (room),
        .m_valid  (m_tvalid),
        .m_res    (m_res),
        .m_ready  (m_tready)
    );

    assign m_tdata = m_res.data;
    assign m_tlast = m_res.last;
    assign m_tuser = m_res.error;

    a_no_accept_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        flushing |-> !s_tready)
        else $error("input accepted while the window drains");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("result pushed into a full output buffer");

    a_advance_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        exc_ctl.advance |-> exc_look.valid)
        else $error("exception pointer advanced past the list");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_res.error) |=> !(push && !push_res.error))
        else $error("error flag cleared without reset");

endmodule

`default_nettype wire

/* bench/x86_branch_target_unfilter_top_test.sv */
// ============================================================================
// x86_branch_target_unfilter_top_test
// Self-checking bench for the streaming x86 branch target unfilter. Sections
// of x86-like bytes, each preceded by its list of exception end offsets, are
// streamed in with random gaps and output stalls. An in-bench model of the
// filter predicts every output byte, its last flag and the sticky error flag.
// ============================================================================

module x86_branch_target_unfilter_top_test;

    import btu_pkg::*;

    localparam logic [7:0] NOP_BYTE = 8'h90;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // exc_end_offset[31:0], data_byte[39:32]
    logic        s_tlast;
    logic        s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic        m_tlast;
    logic        m_tuser;   // error

    bit steady;
    int mismatches;

    logic [7:0]  win_bytes [WIN_LEN];
    int          win_fill;
    logic [31:0] head_pos;
    int          operand_skip;
    bit          jcc_wait;
    logic [31:0] exc_list [EXC_DEPTH];
    int          exc_n;
    int          exc_idx;
    bit          err_sticky;
    res_t        filtered_q [$];

    x86_branch_target_unfilter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_section_state();
        for (int i = 0; i < WIN_LEN; i++) win_bytes[i] = 8'h00;
        win_fill     = 0;
        head_pos     = 32'd0;
        operand_skip = 0;
        jcc_wait     = 1'b0;
        exc_n        = 0;
        exc_idx      = 0;
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input bit lst);
        res_t r;
        r.data  = b;
        r.last  = lst;
        r.error = err_sticky;
        filtered_q.push_back(r);
    endfunction

    // The opcode sits at the window head; its operand is the next four bytes.
    function automatic void rewrite_branch();
        logic [31:0] end_off;
        logic [31:0] target;
        end_off = head_pos + END_INIT;
        if (exc_idx < exc_n && exc_list[exc_idx] == end_off) begin
            exc_idx++;
            return;
        end
        if (win_bytes[1] != OPND_MARK)
            return;
        target = {8'h00, win_bytes[2], win_bytes[3], win_bytes[4]} - end_off;
        win_bytes[1] = target[7:0];
        win_bytes[2] = target[15:8];
        win_bytes[3] = target[23:16];
        win_bytes[4] = target[31:24];
        operand_skip = SKIP_OPND;
    endfunction

    function automatic void unfilter_step(input bit fn, input logic [31:0] off,
                                          input logic [7:0] b, input bit lst);
        logic [7:0] op;
        if (!fn) begin
            if (exc_n < EXC_DEPTH) begin
                exc_list[exc_n] = off;
                exc_n++;
            end else begin
                err_sticky = 1'b1;
            end
            return;
        end
        if (win_fill >= WIN_LEN)
            win_fill = WIN_LEN - 1;
        win_bytes[win_fill] = b;
        win_fill++;
        if (win_fill == WIN_LEN) begin
            op = win_bytes[0];
            if (jcc_wait) begin
                jcc_wait = 1'b0;
                rewrite_branch();
            end else if (operand_skip > 0) begin
                operand_skip--;
            end else if (op == OP_CALL || op == OP_JMP) begin
                rewrite_branch();
            end else if (op == OP_ESC && win_bytes[1] >= JCC_LO && win_bytes[1] <= JCC_HI) begin
                if (lst)
                    err_sticky = 1'b1;
                else
                    jcc_wait = 1'b1;
            end
            expect_byte(win_bytes[0], 1'b0);
            for (int i = 0; i < WIN_LEN - 1; i++) win_bytes[i] = win_bytes[i + 1];
            win_bytes[WIN_LEN - 1] = 8'h00;
            win_fill--;
            head_pos++;
        end
        if (lst) begin
            for (int i = 0; i < win_fill; i++) expect_byte(win_bytes[i], i + 1 == win_fill);
            clear_section_state();
        end
    endfunction

    function automatic void check_filtered_byte();
        res_t want;
        if (filtered_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got data=%h last=%b error=%b",
                     $time, m_tdata, m_tlast, m_tuser);
            mismatches++;
            return;
        end
        want = filtered_q.pop_front();
        if (m_tdata !== want.data) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.data, m_tdata);
            mismatches++;
        end
        if (m_tlast !== want.last) begin
            $display("%0t: out_last expected %b, got %b", $time, want.last, m_tlast);
            mismatches++;
        end
        if (m_tuser !== want.error) begin
            $display("%0t: error expected %b, got %b", $time, want.error, m_tuser);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                unfilter_step(s_tuser, s_tdata[31:0], s_tdata[39:32], s_tlast);
            if (m_tvalid && m_tready)
                check_filtered_byte();
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 19);
    end

    task automatic push_item(input bit fn, input logic [31:0] off,
                             input logic [7:0] b, input bit lst);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= fn ? {b, 32'($urandom)} : {8'($urandom), off};
        s_tlast  <= fn ? lst : 1'($urandom);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_section(input logic [7:0] code_q [$]);
        foreach (code_q[i]) push_item(1'b1, 32'd0, code_q[i], i == code_q.size() - 1);
    endtask

    function automatic logic [7:0] code_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return OP_CALL;
        if (r < 25) return OP_JMP;
        if (r < 35) return OP_ESC;
        if (r < 45) return JCC_LO + 8'($urandom_range(0, 15));
        if (r < 65) return OPND_MARK;
        return 8'($urandom_range(0, 255));
    endfunction

    // Most sections load offsets that match some of their own branches; a few
    // also carry stray offsets and loads in the middle of the byte stream.
    task automatic run_sections(input int budget);
        logic [7:0]  code_q [$];
        logic [31:0] ends_q [$];
        int sent;
        int len;
        bit noisy;
        sent = 0;
        while (sent < budget) begin
            code_q.delete();
            ends_q.delete();
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
            noisy = ($urandom_range(0, 9) < 2);
            for (int i = 0; i < len; i++) code_q.push_back(code_byte());
            if (len >= WIN_LEN && code_q[len - 5] == OP_ESC &&
                code_q[len - 4] >= JCC_LO && code_q[len - 4] <= JCC_HI)
                code_q[len - 5] = NOP_BYTE;
            for (int i = 0; i < len; i++) begin
                if ((code_q[i] == OP_CALL || code_q[i] == OP_JMP) &&
                    $urandom_range(0, 99) < 40)
                    ends_q.push_back(32'(i + 5));
                else if (code_q[i] == OP_ESC && i + 1 < len && code_q[i + 1] >= JCC_LO &&
                         code_q[i + 1] <= JCC_HI && $urandom_range(0, 99) < 40)
                    ends_q.push_back(32'(i + 6));
            end
            if (noisy)
                repeat ($urandom_range(0, 3)) ends_q.insert($urandom_range(0, ends_q.size()),
                                                            $urandom);
            foreach (ends_q[k]) begin
                push_item(1'b0, ends_q[k], 8'h00, 1'b0);
                sent++;
            end
            foreach (code_q[i]) begin
                if (noisy && $urandom_range(0, 19) == 0) begin
                    push_item(1'b0, $urandom, 8'h00, 1'b0);
                    sent++;
                end
                push_item(1'b1, 32'd0, code_q[i], i == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_pass_through();
        logic [7:0] code_q [$];
        code_q = '{8'h00};
        send_section(code_q);
        code_q = '{OP_ESC, JCC_HI, 8'hFF};
        send_section(code_q);
    endtask

    task automatic test_call_operand();
        logic [7:0] code_q [$];
        push_item(1'b0, 32'd5, 8'h00, 1'b0);
        code_q = '{OP_JMP, OPND_MARK, 8'h00, 8'h00, 8'h01,
                   OP_CALL, OPND_MARK, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_section(code_q);
    endtask

    task automatic test_jcc_operand();
        logic [7:0] code_q [$];
        push_item(1'b0, 32'hFFFF_FFFF, 8'h00, 1'b1);
        code_q = '{OP_ESC, 8'h85, OPND_MARK, 8'h01, 8'h02, 8'h03, NOP_BYTE};
        send_section(code_q);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        run_sections(30);
        steady = 1'b0;
    endtask

    task automatic test_random_sections();
        run_sections(20);
    endtask

    task automatic test_jcc_at_end();
        logic [7:0] code_q [$];
        code_q = '{OP_ESC, JCC_LO, 8'h00, 8'h00, 8'h00};
        send_section(code_q);
    endtask

    task automatic test_table_overflow();
        logic [7:0] code_q [$];
        for (int k = 0; k <= EXC_DEPTH; k++) push_item(1'b0, 32'(5 + 7 * k), 8'h00, 1'b0);
        code_q = '{OP_CALL, OPND_MARK, 8'h01, 8'h02, 8'h03,
                   OP_JMP, OPND_MARK, 8'h00, 8'h00, 8'h00, 8'h00};
        send_section(code_q);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        s_tuser    = 1'b0;
        steady     = 1'b0;
        mismatches = 0;
        err_sticky = 1'b0;
        clear_section_state();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_pass_through();
        test_call_operand();
        test_jcc_operand();
        test_steady_stream();
        test_random_sections();
        test_jcc_at_end();
        test_table_overflow();
        drain_results();
        if (mismatches == 0) begin
            $display("x86_branch_target_unfilter_top_test: done, clean");
        end else begin
            $display("x86_branch_target_unfilter_top_test: done, errors");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("x86_branch_target_unfilter_top_test: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/btu_pkg.sv
rtl/core/btu_ram.sv
rtl/core/btu_exc_list.sv
rtl/core/btu_scan.sv
rtl/core/btu_skid.sv
rtl/core/x86_branch_target_unfilter_top.sv
bench/x86_branch_target_unfilter_top_test.sv
